### design/scalar_to_false_color_pixel_unit_macros.svh
// Assertion macros for the false-color pixel unit.
`ifndef SCALAR_TO_FALSE_COLOR_PIXEL_UNIT_MACROS_SVH
`define SCALAR_TO_FALSE_COLOR_PIXEL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define STFC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("stfc: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define STFC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("stfc: next-cycle property failed");

`else

`define STFC_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define STFC_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

### design/stfc_pkg.sv
// Shared types and constants of the false-color pixel unit.
package stfc_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_INDEX_BITS  = 8;
	localparam int COLOR_BITS      = 8;
	localparam int RGB_BITS        = 3 * COLOR_BITS;
	localparam int PIXEL_BITS      = 32;
	localparam int FRAC_BITS       = 8;
	localparam int QUO_BITS        = PAL_INDEX_BITS + FRAC_BITS;
	localparam int CFG_DATA_BITS   = SAMPLE_BITS;
	localparam int CFG_INDEX_BITS  = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_BOUND  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_BOUND = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_MODE = 2'd2;

	localparam logic CMD_PALETTE_WRITE = 1'b0;
	localparam logic CMD_MAP_SAMPLE    = 1'b1;

	localparam logic signed [SAMPLE_BITS-1:0] LOW_BOUND_RESET  = '0;
	localparam logic signed [SAMPLE_BITS-1:0] HIGH_BOUND_RESET = SAMPLE_BITS'(13107);

	// 255 * 256: top of the palette with zero weight
	localparam logic [QUO_BITS-1:0]   FULL_SCALE = QUO_BITS'(65280);
	localparam logic [COLOR_BITS-1:0] GREY_ALPHA = 8'hFF;

	typedef struct packed {
		logic                          command;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          end_of_frame;
		logic [PAL_INDEX_BITS-1:0]     palette_index;
		logic [COLOR_BITS-1:0]         palette_red;
		logic [COLOR_BITS-1:0]         palette_green;
		logic [COLOR_BITS-1:0]         palette_blue;
	} in_item_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel_word;
		logic                  frame_end;
	} out_item_t;

endpackage

### design/stfc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module stfc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/scalar_to_false_color_pixel_unit.sv
// Top level of the false-color pixel unit: scaling pipeline, palette RAMs, result queue.
//
//   channel | signals                          | direction | moves
//   --------+----------------------------------+-----------+-----------------------------
//   in      | in_valid, in_stall, in_item      | to block  | palette write or sample item
//   out     | out_valid, out_stall, out_item   | from block| pixel item (map items only)
//   cfg     | cfg_write, cfg_index, cfg_data   | to block  | bound and mode register write
//
// One item per clock sustained while in_stall is low; a map item's pixel is written to the
// queue after s1, s2, the s3 dividend load, the 16-stage restoring quotient pipeline and the
// registered palette read. Reset clears the pipeline valids, the queue pointers, the
// credit count and the registers; the palette RAM holds no reset value.
// in_stall rises only when RESULT_DEPTH pixels are in flight or queued, so out_stall
// never stalls the pipeline itself; the queue absorbs it.

`include "scalar_to_false_color_pixel_unit_macros.svh"

module scalar_to_false_color_pixel_unit #(
	// result queue depth, a power of two from 2 to 32; 22 or more keeps full rate
	parameter int RESULT_DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  stfc_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output stfc_pkg::out_item_t                 out_item,
	input  logic                                cfg_write,
	input  logic [stfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [stfc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import stfc_pkg::*;

	localparam int W         = SAMPLE_BITS;
	localparam int DIV_STEPS = QUO_BITS;
	localparam int PW        = $clog2(RESULT_DEPTH);
	localparam logic [PW:0] CREDIT_MAX = (PW + 1)'(RESULT_DEPTH);

	// what an item carries alongside its arithmetic
	typedef struct packed {
		logic                      command;
		logic                      eof;
		logic [PAL_INDEX_BITS-1:0] pal_index;
		logic [RGB_BITS-1:0]       pal_rgb;
	} ctx_t;

	// ---------------------------------------------------------------- configuration
	logic signed [W-1:0] low_bound_q;
	logic signed [W-1:0] high_bound_q;
	logic                color_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q  <= LOW_BOUND_RESET;
			high_bound_q <= HIGH_BOUND_RESET;
			color_mode_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LOW_BOUND:  low_bound_q  <= $signed(cfg_data[W-1:0]);
				REG_HIGH_BOUND: high_bound_q <= $signed(cfg_data[W-1:0]);
				REG_COLOR_MODE: color_mode_q <= cfg_data[0];
				default: ; // unknown index: ignored
			endcase
		end
	end

	// ---------------------------------------------------------------- input handshake
	logic [PW:0] credit_q;
	logic        in_take;
	logic        in_map;
	logic        out_take;

	assign in_stall = (credit_q == CREDIT_MAX);
	assign in_take  = in_valid && !in_stall;
	assign in_map   = in_take && (in_item.command == CMD_MAP_SAMPLE);

	// ---------------------------------------------------------------- s1: differences
	logic signed [W:0] num_c;
	logic signed [W:0] den_c;
	ctx_t              ctx_c;

	logic              valid_s1;
	logic signed [W:0] num_s1;
	logic signed [W:0] den_s1;
	ctx_t              ctx_s1;

	always_comb begin
		num_c = $signed({high_bound_q[W-1], high_bound_q}) -
			$signed({in_item.sample[W-1], in_item.sample});
		den_c = $signed({high_bound_q[W-1], high_bound_q}) -
			$signed({low_bound_q[W-1], low_bound_q});
		ctx_c.command   = in_item.command;
		ctx_c.eof       = in_item.end_of_frame;
		ctx_c.pal_index = in_item.palette_index;
		ctx_c.pal_rgb   = {in_item.palette_red, in_item.palette_green, in_item.palette_blue};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= num_c;
		den_s1 <= den_c;
		ctx_s1 <= ctx_c;
	end

	// ---------------------------------------------------------------- s2: magnitudes
	// Opposite signs or equal bounds give scaled = 0.
	logic signed [W:0] an_full_c;
	logic signed [W:0] ad_full_c;

	logic          valid_s2;
	logic [W-1:0]  an_s2;
	logic [W-1:0]  ad_s2;
	logic          zero_s2;
	ctx_t          ctx_s2;

	always_comb begin
		an_full_c = num_s1[W] ? -num_s1 : num_s1;
		ad_full_c = den_s1[W] ? -den_s1 : den_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		an_s2   <= an_full_c[W-1:0];
		ad_s2   <= ad_full_c[W-1:0];
		zero_s2 <= (den_s1 == '0) || (num_s1[W] != den_s1[W]);
		ctx_s2  <= ctx_s1;
	end

	// ---------------------------------------------------------------- s3: dividend
	// an * 65280 = (an << 16) - (an << 8). an >= ad saturates to the palette top,
	// otherwise the quotient fits 16 bits and the upper dividend part is below ad.
	logic [W+QUO_BITS-1:0] prod_c;

	assign prod_c = {an_s2, {QUO_BITS{1'b0}}} -
		{{FRAC_BITS{1'b0}}, an_s2, {FRAC_BITS{1'b0}}};

	// Divider pipeline: entry 0 is loaded at s3, entry i sits i stages later.
	logic                dv_valid_sd [0:DIV_STEPS];
	logic [W-1:0]        dv_rem_sd   [0:DIV_STEPS];
	logic [QUO_BITS-1:0] dv_nlo_sd   [0:DIV_STEPS];
	logic [QUO_BITS-1:0] dv_quo_sd   [0:DIV_STEPS];
	logic [W-1:0]        dv_ad_sd    [0:DIV_STEPS];
	logic                dv_sat_sd   [0:DIV_STEPS];
	logic                dv_zero_sd  [0:DIV_STEPS];
	ctx_t                dv_ctx_sd   [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid_sd[0] <= 1'b0;
		end else begin
			dv_valid_sd[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dv_rem_sd[0]  <= prod_c[W+QUO_BITS-1 -: W];
		dv_nlo_sd[0]  <= prod_c[QUO_BITS-1:0];
		dv_quo_sd[0]  <= '0;
		dv_ad_sd[0]   <= ad_s2;
		dv_sat_sd[0]  <= (an_s2 >= ad_s2);
		dv_zero_sd[0] <= zero_s2;
		dv_ctx_sd[0]  <= ctx_s2;
	end

	// one restoring quotient bit per stage, MSB first
	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
		logic [W:0] trial;
		logic [W:0] diff;
		logic       take;

		always_comb begin
			trial = {dv_rem_sd[i-1], dv_nlo_sd[i-1][QUO_BITS-1]};
			diff  = trial - {1'b0, dv_ad_sd[i-1]};
			take  = (trial >= {1'b0, dv_ad_sd[i-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_sd[i] <= 1'b0;
			end else begin
				dv_valid_sd[i] <= dv_valid_sd[i-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_sd[i]  <= take ? diff[W-1:0] : trial[W-1:0];
			dv_nlo_sd[i]  <= {dv_nlo_sd[i-1][QUO_BITS-2:0], 1'b0};
			dv_quo_sd[i]  <= {dv_quo_sd[i-1][QUO_BITS-2:0], take};
			dv_ad_sd[i]   <= dv_ad_sd[i-1];
			dv_sat_sd[i]  <= dv_sat_sd[i-1];
			dv_zero_sd[i] <= dv_zero_sd[i-1];
			dv_ctx_sd[i]  <= dv_ctx_sd[i-1];
		end
	end

	// ---------------------------------------------------------------- palette access
	// Writes and reads both happen here, so they stay in item order: a map item
	// right behind a write reads the entry in the cycle after it was written.
	logic [QUO_BITS-1:0]       scaled_c;
	logic [PAL_INDEX_BITS-1:0] idx_c;
	logic [PAL_INDEX_BITS-1:0] idx_next_c;
	logic                      pal_we;
	ctx_t                      ctx_last;

	assign ctx_last = dv_ctx_sd[DIV_STEPS];

	always_comb begin
		priority if (dv_zero_sd[DIV_STEPS]) begin
			scaled_c = '0;
		end else if (dv_sat_sd[DIV_STEPS]) begin
			scaled_c = FULL_SCALE;
		end else begin
			scaled_c = dv_quo_sd[DIV_STEPS];
		end
		idx_c      = scaled_c[QUO_BITS-1 -: PAL_INDEX_BITS];
		// wraps at the top; weight is zero there so the entry does not matter
		idx_next_c = idx_c + 1'b1;
		pal_we     = dv_valid_sd[DIV_STEPS] && (ctx_last.command == CMD_PALETTE_WRITE);
	end

	logic                      valid_s20;
	logic [PAL_INDEX_BITS-1:0] idx_s20;
	logic [FRAC_BITS-1:0]      w_s20;
	logic                      eof_s20;
	logic [RGB_BITS-1:0]       pal_lo_s20;
	logic [RGB_BITS-1:0]       pal_hi_s20;

	stfc_ram #(
		.WIDTH (RGB_BITS),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_lo (
		.clk   (clk),
		.we    (pal_we),
		.waddr (ctx_last.pal_index),
		.wdata (ctx_last.pal_rgb),
		.raddr (idx_c),
		.rdata (pal_lo_s20)
	);

	stfc_ram #(
		.WIDTH (RGB_BITS),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_hi (
		.clk   (clk),
		.we    (pal_we),
		.waddr (ctx_last.pal_index),
		.wdata (ctx_last.pal_rgb),
		.raddr (idx_next_c),
		.rdata (pal_hi_s20)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s20 <= 1'b0;
		end else begin
			valid_s20 <= dv_valid_sd[DIV_STEPS] && (ctx_last.command == CMD_MAP_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		idx_s20 <= idx_c;
		w_s20   <= scaled_c[FRAC_BITS-1:0];
		eof_s20 <= ctx_last.eof;
	end

	// ---------------------------------------------------------------- blend
	// a + floor(w * (b - a) / 256), kept to 8 bits
	function automatic logic [COLOR_BITS-1:0] blend_chan(
		input logic [COLOR_BITS-1:0] a,
		input logic [COLOR_BITS-1:0] b,
		input logic [FRAC_BITS-1:0]  w
	);
		logic signed [COLOR_BITS:0]             d;
		logic signed [COLOR_BITS+FRAC_BITS+1:0] t;
		logic [COLOR_BITS-1:0]                  f;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		t = $signed({1'b0, w}) * d;
		f = t[FRAC_BITS+COLOR_BITS-1:FRAC_BITS];
		return a + f;
	endfunction

	logic [RGB_BITS-1:0]   pal_b_c;
	logic [COLOR_BITS-1:0] red_c;
	logic [COLOR_BITS-1:0] green_c;
	logic [COLOR_BITS-1:0] blue_c;
	logic [PIXEL_BITS-1:0] pixel_c;

	always_comb begin
		// zero weight never looks at the next entry, which may still be unwritten
		pal_b_c = (w_s20 == '0) ? pal_lo_s20 : pal_hi_s20;
		red_c   = blend_chan(pal_lo_s20[RGB_BITS-1 -: COLOR_BITS],
			pal_b_c[RGB_BITS-1 -: COLOR_BITS], w_s20);
		green_c = blend_chan(pal_lo_s20[2*COLOR_BITS-1 -: COLOR_BITS],
			pal_b_c[2*COLOR_BITS-1 -: COLOR_BITS], w_s20);
		blue_c  = blend_chan(pal_lo_s20[COLOR_BITS-1:0],
			pal_b_c[COLOR_BITS-1:0], w_s20);
		if (color_mode_q) begin
			pixel_c = {red_c, green_c, blue_c, idx_s20};
		end else begin
			pixel_c = {GREY_ALPHA, idx_s20, idx_s20, idx_s20};
		end
	end

	// ---------------------------------------------------------------- result queue
	// Credits count map items from acceptance until their pixel is taken, so the
	// queue always has room for everything in the pipeline.
	out_item_t   res_mem_q [0:RESULT_DEPTH-1];
	logic [PW:0] wr_ptr_q;
	logic [PW:0] rd_ptr_q;
	logic [PW:0] res_fill;
	logic        res_full;

	assign res_fill  = wr_ptr_q - rd_ptr_q;
	assign res_full  = (res_fill == CREDIT_MAX);
	assign out_valid = (wr_ptr_q != rd_ptr_q);
	assign out_item  = res_mem_q[rd_ptr_q[PW-1:0]];
	assign out_take  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (valid_s20) begin
			res_mem_q[wr_ptr_q[PW-1:0]] <= '{pixel_word: pixel_c, frame_end: eof_s20};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			credit_q <= '0;
		end else begin
			if (valid_s20) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (in_map && !out_take) begin
				credit_q <= credit_q + 1'b1;
			end else if (!in_map && out_take) begin
				credit_q <= credit_q - 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- assertions
	`STFC_ASSERT_NOW(a_queue_no_overflow, clk, arst_n, valid_s20, !res_full)
	`STFC_ASSERT_NOW(a_pixel_has_credit, clk, arst_n, out_valid, credit_q != '0)
	`STFC_ASSERT_NOW(a_rem_below_divisor, clk, arst_n, dv_valid_sd[DIV_STEPS] && !dv_sat_sd[DIV_STEPS] && !dv_zero_sd[DIV_STEPS], dv_rem_sd[DIV_STEPS] < dv_ad_sd[DIV_STEPS])
	`STFC_ASSERT_NEXT(a_credit_counts_up, clk, arst_n, in_map && !out_take, credit_q == $past(credit_q) + 1'b1)

endmodule
